[hdl/eadcm_pkg.sv]
// ----------------------------------------------------------------------------
// eadcm_pkg
// Shared constants, types and the CORDIC angle table for the attitude to
// direction cosine matrix unit.
// ----------------------------------------------------------------------------
package eadcm_pkg;

   localparam int ANGLE_BITS    = 32;
   localparam int FRAC_BITS     = 30;
   localparam int CORDIC_STAGES = 24;
   localparam int GUARD         = 2;

   // CORDIC datapath width: sign, integer bit, FRAC_BITS+GUARD fraction, growth
   localparam int CW = FRAC_BITS + GUARD + 3;
   // element width: value within [-2^FRAC_BITS, 2^FRAC_BITS]
   localparam int EW = FRAC_BITS + 2;
   // sum of two products with headroom
   localparam int SW = FRAC_BITS + 4;

   localparam logic [63:0] GAIN_Q32 = 64'h9B74EDA8;
   localparam logic [63:0] X_INIT64 =
      ((GAIN_Q32 << (FRAC_BITS + GUARD)) + 64'h80000000) >> 32;
   localparam logic signed [CW-1:0] X_INIT = CW'(X_INIT64);

   localparam logic signed [EW-1:0] ONE  = EW'(64'd1 << FRAC_BITS);
   localparam logic signed [EW-1:0] MONE = -ONE;

   typedef logic signed [CW-1:0] cval_type;
   typedef logic signed [32:0]   zval_type;
   typedef logic signed [EW-1:0] elem_type;
   typedef logic [1:0]           quad_type;

   typedef struct packed {
      cval_type x;
      cval_type y;
      zval_type z;
   } vec_type;

   // one CORDIC vector per angle: yaw, pitch, roll
   typedef struct packed {
      vec_type  yaw;
      vec_type  pitch;
      vec_type  roll;
      quad_type q_yaw;
      quad_type q_pitch;
      quad_type q_roll;
   } cell_word_type;

   function automatic zval_type atan_entry(input int n);
      logic [31:0] t;
      case (n)
         0: t = 536870912;  1: t = 316933406;  2: t = 167458907;
         3: t = 85004756;   4: t = 42667331;   5: t = 21354465;
         6: t = 10679838;   7: t = 5340245;    8: t = 2670163;
         9: t = 1335087;    10: t = 667544;    11: t = 333772;
         12: t = 166886;    13: t = 83443;     14: t = 41722;
         15: t = 20861;     16: t = 10430;     17: t = 5215;
         18: t = 2608;      19: t = 1304;      20: t = 652;
         21: t = 326;       22: t = 163;       23: t = 81;
         24: t = 41;        25: t = 20;        26: t = 10;
         27: t = 5;         28: t = 3;         29: t = 1;
         default: t = 0;
      endcase
      return zval_type'({1'b0, t});
   endfunction

   function automatic elem_type clamp_unit(input logic signed [SW-1:0] v);
      if (v > SW'(ONE)) return ONE;
      if (v < SW'(MONE)) return MONE;
      return EW'(v);
   endfunction

   // round-to-nearest fixed-point product, floor after adding half
   function automatic logic signed [SW-1:0] fx_mul(input elem_type a, input elem_type b);
      logic signed [2*EW-1:0] p;
      p = a * b;
      p = p + $signed((2*EW)'(64'd1 << (FRAC_BITS - 1)));
      return SW'(p >>> FRAC_BITS);
   endfunction

endpackage

[hdl/eadcm_cell.sv]
// ----------------------------------------------------------------------------
// eadcm_cell
// One CORDIC micro-rotation for all three angles; hands its word on.
// ----------------------------------------------------------------------------
module eadcm_cell
   import eadcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic [4:0]    stage,
   input  logic          in_valid,
   input  cell_word_type in_word,
   output logic          out_valid,
   output cell_word_type out_word
);

   logic          valid_ff, valid_in;
   cell_word_type word_ff, word_in;

   function automatic vec_type rotate(input vec_type v);
      vec_type r;
      cval_type dx, dy;
      dx = v.y >>> stage;
      dy = v.x >>> stage;
      if (!v.z[32]) begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.z = v.z - atan_entry(int'(stage));
      end else begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.z = v.z + atan_entry(int'(stage));
      end
      return r;
   endfunction

   always_comb begin
      valid_in        = in_valid;
      word_in         = in_word;
      word_in.yaw     = rotate(in_word.yaw);
      word_in.pitch   = rotate(in_word.pitch);
      word_in.roll    = rotate(in_word.roll);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[hdl/eadcm_matrix.sv]
// ----------------------------------------------------------------------------
// eadcm_matrix
// Quadrant fix-up, then products and sums in three registered stages.
// ----------------------------------------------------------------------------
module eadcm_matrix
   import eadcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  cell_word_type in_word,
   output logic          out_valid,
   output elem_type      elem [9]
);

   logic [2:0] valid_ff;
   elem_type sk_ff, ck_ff, si_ff, ci_ff, sj_ff, cj_ff;
   elem_type sk_in, ck_in, si_in, ci_in, sj_in, cj_in;
   elem_type sisj_ff, sicj_ff, cjck_ff, cisk_ff, sjck_ff, cjsk_ff, cick_ff;
   elem_type sjsk_ff, cisj_ff, cicj_ff, sk2_ff, ck2_ff, si2_ff;
   elem_type out_ff [9];
   elem_type out_in [9];

   function automatic elem_type round_out(input cval_type v);
      cval_type t;
      t = (v + cval_type'(2)) >>> GUARD;
      return clamp_unit(SW'(t));
   endfunction

   task automatic fold(input vec_type v, input quad_type q,
                       output elem_type sn, output elem_type cs);
      elem_type c, s;
      c = round_out(v.x);
      s = round_out(v.y);
      case (q)
         2'd0: begin cs = c;  sn = s;  end
         2'd1: begin cs = -s; sn = c;  end
         2'd2: begin cs = -c; sn = -s; end
         default: begin cs = s; sn = -c; end
      endcase
   endtask

   always_comb begin
      fold(in_word.yaw,   in_word.q_yaw,   sk_in, ck_in);
      fold(in_word.pitch, in_word.q_pitch, si_in, ci_in);
      fold(in_word.roll,  in_word.q_roll,  sj_in, cj_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // stage 1: fold quadrants
   // stage 2: pair products
   // stage 3: triple products and sums
   always_ff @(posedge clock) begin
      if (enable) begin
         sk_ff <= sk_in; ck_ff <= ck_in; si_ff <= si_in;
         ci_ff <= ci_in; sj_ff <= sj_in; cj_ff <= cj_in;
         sisj_ff <= EW'(fx_mul(si_ff, sj_ff));
         sicj_ff <= EW'(fx_mul(si_ff, cj_ff));
         cjck_ff <= EW'(fx_mul(cj_ff, ck_ff));
         cisk_ff <= EW'(fx_mul(ci_ff, sk_ff));
         sjck_ff <= EW'(fx_mul(sj_ff, ck_ff));
         cjsk_ff <= EW'(fx_mul(cj_ff, sk_ff));
         cick_ff <= EW'(fx_mul(ci_ff, ck_ff));
         sjsk_ff <= EW'(fx_mul(sj_ff, sk_ff));
         cisj_ff <= EW'(fx_mul(ci_ff, sj_ff));
         cicj_ff <= EW'(fx_mul(ci_ff, cj_ff));
         sk2_ff  <= sk_ff;
         ck2_ff  <= ck_ff;
         si2_ff  <= si_ff;
         out_ff  <= out_in;
      end
   end

   always_comb begin
      out_in[0] = clamp_unit(SW'(cjck_ff) - fx_mul(sisj_ff, sk2_ff));
      out_in[1] = clamp_unit(-SW'(cisk_ff));
      out_in[2] = clamp_unit(SW'(sjck_ff) + fx_mul(sicj_ff, sk2_ff));
      out_in[3] = clamp_unit(SW'(cjsk_ff) + fx_mul(sisj_ff, ck2_ff));
      out_in[4] = cick_ff;
      out_in[5] = clamp_unit(SW'(sjsk_ff) - fx_mul(sicj_ff, ck2_ff));
      out_in[6] = clamp_unit(-SW'(cisj_ff));
      out_in[7] = si2_ff;
      out_in[8] = cicj_ff;
   end

   assign out_valid = valid_ff[2];
   assign elem      = out_ff;

endmodule

[hdl/euler_attitude_to_dcm_unit.sv]
// ----------------------------------------------------------------------------
// euler_attitude_to_dcm_unit
// Yaw, pitch and roll binary angles to the body-to-navigation direction
// cosine matrix, Q1.30 elements, through a chain of CORDIC cells.
// ----------------------------------------------------------------------------
//
//   channel | ports         | direction | word
//   --------+---------------+-----------+-------------------------------
//   request | req_*         | in        | yaw, pitch, roll angles
//   result  | rsp_*         | out       | nine matrix elements
//
// One word enters per cycle unless the chain is stalled. A word passes one entry
// stage, CORDIC_STAGES cells, three matrix stages and the output register.
// Reset clears all valid bits; payload registers are not reset.
// The pipeline advances while the output register is empty or taken; on a
// stall the whole chain holds, so req_stall follows rsp_stall when full.
//
module euler_attitude_to_dcm_unit
   import eadcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_yaw_angle,
   input  logic signed [31:0] req_pitch_angle,
   input  logic signed [31:0] req_roll_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_elem_r0_c0,
   output logic signed [31:0] rsp_elem_r0_c1,
   output logic signed [31:0] rsp_elem_r0_c2,
   output logic signed [31:0] rsp_elem_r1_c0,
   output logic signed [31:0] rsp_elem_r1_c1,
   output logic signed [31:0] rsp_elem_r1_c2,
   output logic signed [31:0] rsp_elem_r2_c0,
   output logic signed [31:0] rsp_elem_r2_c1,
   output logic signed [31:0] rsp_elem_r2_c2
);

   localparam logic [31:0] KEEP = 32'hFFFFFFFF << (32 - ANGLE_BITS);

   logic          enable;
   logic          entry_valid_ff;
   cell_word_type entry_ff, entry_in;
   logic          chain_valid [CORDIC_STAGES+1];
   cell_word_type chain_word  [CORDIC_STAGES+1];
   logic          mat_valid;
   elem_type      mat_elem [9];
   logic          rsp_valid_ff;
   elem_type      rsp_ff [9];

   // advance whenever the output register is free or being taken
   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   // quadrant reduction: centered residual in [-pi/4, pi/4)
   function automatic void reduce(input logic [31:0] raw,
                                  output vec_type v, output quad_type q);
      logic [31:0] w;
      w   = (raw & KEEP) + 32'h20000000;
      q   = w[31:30];
      v.x = X_INIT;
      v.y = '0;
      v.z = zval_type'({3'b000, w[29:0]}) - zval_type'(33'sh20000000);
   endfunction

   always_comb begin
      reduce(req_yaw_angle,   entry_in.yaw,   entry_in.q_yaw);
      reduce(req_pitch_angle, entry_in.pitch, entry_in.q_pitch);
      reduce(req_roll_angle,  entry_in.roll,  entry_in.q_roll);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (enable) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         entry_ff <= entry_in;
      end
   end

   assign chain_valid[0] = entry_valid_ff;
   assign chain_word[0]  = entry_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      eadcm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage     (5'(g)),
         .in_valid  (chain_valid[g]),
         .in_word   (chain_word[g]),
         .out_valid (chain_valid[g+1]),
         .out_word  (chain_word[g+1])
      );
   end

   eadcm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_word   (chain_word[CORDIC_STAGES]),
      .out_valid (mat_valid),
      .elem      (mat_elem)
   );

   // output register: load when free or taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= mat_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= mat_elem;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_elem_r0_c0 = 32'(rsp_ff[0]);
   assign rsp_elem_r0_c1 = 32'(rsp_ff[1]);
   assign rsp_elem_r0_c2 = 32'(rsp_ff[2]);
   assign rsp_elem_r1_c0 = 32'(rsp_ff[3]);
   assign rsp_elem_r1_c1 = 32'(rsp_ff[4]);
   assign rsp_elem_r1_c2 = 32'(rsp_ff[5]);
   assign rsp_elem_r2_c0 = 32'(rsp_ff[6]);
   assign rsp_elem_r2_c1 = 32'(rsp_ff[7]);
   assign rsp_elem_r2_c2 = 32'(rsp_ff[8]);

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_elem_r1_c1))
      else $error("result word changed under stall");

   a_req_stall : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while output free");

   a_r11_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_elem_r1_c1 <= 32'sd1073741824 &&
                    rsp_elem_r1_c1 >= -32'sd1073741824)
      else $error("element out of unit range");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Attitude to direction cosine matrix unit testbench
// Drives yaw, pitch and roll binary angles through the request channel,
// predicts the nine Q1.30 matrix elements with a bit-exact CORDIC model and
// compares every result word in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
   import eadcm_pkg::*;
;

   typedef struct {
      logic [31:0] yaw;
      logic [31:0] pitch;
      logic [31:0] roll;
   } angles_type;

   typedef struct {
      logic [31:0] e [9];
   } matrix_type;

   localparam int RANDOM_WORDS = 1200;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_yaw_angle = '0;
   logic signed [31:0] req_pitch_angle = '0;
   logic signed [31:0] req_roll_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_elem [9];

   angles_type pending_angles[$];
   matrix_type expected_matrices[$];
   int error_count = 0;
   longint cycle_count = 0;
   bit stimulus_done = 1'b0;
   bit calm_phase = 1'b0;   // no idling on either side while set
   bit hold_sender = 1'b0;  // sender pauses until the pipeline drains

   euler_attitude_to_dcm_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_yaw_angle(req_yaw_angle), .req_pitch_angle(req_pitch_angle),
      .req_roll_angle(req_roll_angle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_elem_r0_c0(rsp_elem[0]), .rsp_elem_r0_c1(rsp_elem[1]),
      .rsp_elem_r0_c2(rsp_elem[2]), .rsp_elem_r1_c0(rsp_elem[3]),
      .rsp_elem_r1_c1(rsp_elem[4]), .rsp_elem_r1_c2(rsp_elem[5]),
      .rsp_elem_r2_c0(rsp_elem[6]), .rsp_elem_r2_c1(rsp_elem[7]),
      .rsp_elem_r2_c2(rsp_elem[8])
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint unit_clamp(input longint v);
      longint one;
      one = longint'(1) << FRAC_BITS;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
   endfunction

   // rounded Q product: add half, then floor shift
   function automatic longint q_product(input longint a, input longint b);
      return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic longint arc_step(input int n);
      case (n)
         0: return 536870912;  1: return 316933406;  2: return 167458907;
         3: return 85004756;   4: return 42667331;   5: return 21354465;
         6: return 10679838;   7: return 5340245;    8: return 2670163;
         9: return 1335087;    10: return 667544;    11: return 333772;
         12: return 166886;    13: return 83443;     14: return 41722;
         15: return 20861;     16: return 10430;     17: return 5215;
         18: return 2608;      19: return 1304;      20: return 652;
         21: return 326;       22: return 163;       23: return 81;
         24: return 41;        25: return 20;        26: return 10;
         27: return 5;         28: return 3;         29: return 1;
         default: return 0;
      endcase
   endfunction

   task automatic sine_cosine(input logic [31:0] angle, output longint sn,
                              output longint cs);
      logic [31:0] kept, shifted;
      logic [1:0] quad;
      longint x, y, z, dx, dy, c, s;
      kept = angle & (32'hFFFF_FFFF << (32 - ANGLE_BITS));
      shifted = kept + 32'h2000_0000;
      quad = shifted[31:30];
      z = longint'(shifted[29:0]) - 64'sh2000_0000;
      x = longint'((64'h9B74EDA8 * (64'd1 << (FRAC_BITS + 2)) + 64'h8000_0000) >> 32);
      y = 0;
      for (int n = 0; n < CORDIC_STAGES && n < 30; n++) begin
         dx = y >>> n;
         dy = x >>> n;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arc_step(n);
         end else begin
            x += dx; y -= dy; z += arc_step(n);
         end
      end
      c = unit_clamp((x + 2) >>> 2);
      s = unit_clamp((y + 2) >>> 2);
      case (quad)
         2'd0: begin cs = c;  sn = s;  end
         2'd1: begin cs = -s; sn = c;  end
         2'd2: begin cs = -c; sn = -s; end
         default: begin cs = s; sn = -c; end
      endcase
   endtask

   task automatic predict_matrix(input angles_type a, output matrix_type m);
      longint sk, ck, si, ci, sj, cj;
      longint e [9];
      sine_cosine(a.yaw, sk, ck);
      sine_cosine(a.pitch, si, ci);
      sine_cosine(a.roll, sj, cj);
      e[0] = q_product(cj, ck) - q_product(q_product(si, sj), sk);
      e[1] = -q_product(ci, sk);
      e[2] = q_product(sj, ck) + q_product(q_product(si, cj), sk);
      e[3] = q_product(cj, sk) + q_product(q_product(si, sj), ck);
      e[4] = q_product(ci, ck);
      e[5] = q_product(sj, sk) - q_product(q_product(si, cj), ck);
      e[6] = -q_product(ci, sj);
      e[7] = si;
      e[8] = q_product(ci, cj);
      for (int k = 0; k < 9; k++) m.e[k] = 32'(unit_clamp(e[k]));
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   // ---------------------------------------------------------------- driver
   // Accept at the rising edge, then advance or idle at the falling edge.
   bit word_taken;
   always @(posedge clock) word_taken <= !reset && req_valid && !req_stall;

   always @(negedge clock) begin
      matrix_type m;
      if (!reset && (!req_valid || word_taken)) begin
         if (word_taken) begin
            predict_matrix(pending_angles.pop_front(), m);
            expected_matrices.push_back(m);
         end
         if (pending_angles.size() > 0 && !hold_sender &&
             (calm_phase || $urandom_range(99) >= 20)) begin
            req_valid <= 1'b1;
            req_yaw_angle <= pending_angles[0].yaw;
            req_pitch_angle <= pending_angles[0].pitch;
            req_roll_angle <= pending_angles[0].roll;
         end else begin
            req_valid <= 1'b0;
         end
      end
      // stall the result side at random
      rsp_stall <= !calm_phase && ($urandom_range(99) < 20);
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      matrix_type m;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matrices.size() == 0) begin
            report_mismatch("result word with no expectation");
         end else begin
            m = expected_matrices.pop_front();
            for (int k = 0; k < 9; k++)
               if (rsp_elem[k] !== m.e[k])
                  report_mismatch($sformatf("element r%0d_c%0d got %h want %h",
                                            k / 3, k % 3, rsp_elem[k], m.e[k]));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic queue_angles(input logic [31:0] y, input logic [31:0] p,
                               input logic [31:0] r);
      angles_type a;
      a.yaw = y; a.pitch = p; a.roll = r;
      pending_angles.push_back(a);
   endtask

   function automatic logic [31:0] random_angle();
      // mix fully random angles with ones near the quadrant boundaries
      case ($urandom_range(3))
         0: return {2'($urandom_range(3)), 30'd0} + 32'($urandom_range(8)) - 32'd4;
         1: return {3'($urandom_range(7)), 29'd0} ^ 32'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] edges [8];
      edges = '{32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                32'h2000_0000, 32'h1FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: quadrant boundaries, octant edges and the field extremes
      for (int k = 0; k < 8; k++) queue_angles(edges[k], edges[(k + 3) % 8],
                                               edges[(k + 5) % 8]);
      for (int k = 0; k < 8; k++) queue_angles(edges[k], edges[k], edges[k]);
      queue_angles(32'h5555_5555, 32'hAAAA_AAAA, 32'h6000_0000);
      queue_angles(32'hE000_0000, 32'hA000_0000, 32'h0000_0001);
      wait (pending_angles.size() == 0);
      // drain the pipeline with the sender held off
      hold_sender = 1'b1;
      wait (expected_matrices.size() == 0 && !req_valid);
      hold_sender = 1'b0;
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         queue_angles(random_angle(), random_angle(), random_angle());
         if (k == 400) begin
            wait (pending_angles.size() == 0);
            calm_phase = 1'b1;
         end
         if (k == 700) begin
            wait (pending_angles.size() == 0);
            calm_phase = 1'b0;
         end
      end
      wait (pending_angles.size() == 0 && expected_matrices.size() == 0);
      repeat (CORDIC_STAGES + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
